// ----- design/hrhs_pkg.sv -----
// ----------------------------------------------------------------------------
// HTTP response header stripper: shared package
// Payload types, queue entry type, codes and constants that the front,
// the queue and the back of the stripper share.
// ----------------------------------------------------------------------------
package hrhs_pkg;

  localparam int unsigned CAP_W          = 20;
  localparam int unsigned STATUS_W       = 16;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 20'd65536;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] ASCII_CR    = 8'h0D;
  localparam logic [7:0] ASCII_LF    = 8'h0A;
  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;

  localparam logic [STATUS_W-1:0] WEIGHT_HUNDREDS = 16'd100;
  localparam logic [STATUS_W-1:0] WEIGHT_TENS     = 16'd10;

  // Result kinds.
  localparam logic KIND_BODY    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Summary error codes.
  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_NO_BYTES = 2'd1,
    ERR_NO_DELIM = 2'd2
  } hrhs_err_t;

  // Status field tracker, one-hot.
  typedef enum logic [5:0] {
    PH_SEEK_SPACE = 6'b000001,
    PH_DIGIT1     = 6'b000010,
    PH_DIGIT2     = 6'b000100,
    PH_DIGIT3     = 6'b001000,
    PH_NEED_MORE  = 6'b010000,
    PH_VALID      = 6'b100000
  } hrhs_phase_t;

  // Header delimiter matcher, one-hot: bytes of CR LF CR LF seen so far.
  typedef enum logic [3:0] {
    DLM_NONE     = 4'b0001,
    DLM_CR       = 4'b0010,
    DLM_CRLF     = 4'b0100,
    DLM_CRLFCR   = 4'b1000
  } hrhs_dlm_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_response;
  } hrhs_in_t;

  typedef struct packed {
    logic                       kind;
    logic [7:0]                 body_byte;
    logic signed [STATUS_W-1:0] status_code;
    logic [1:0]                 error_code;
    logic [CAP_W-1:0]           body_length;
    logic                       last_result;
  } hrhs_out_t;

  // One queue entry: the results that one accepted item causes.
  typedef struct packed {
    logic                has_byte;
    logic                has_sum;
    logic [7:0]          body_byte;
    logic [STATUS_W-1:0] status_code;
    logic [1:0]          error_code;
    logic [CAP_W-1:0]    body_length;
  } hrhs_entry_t;

endpackage

// ----- design/hrhs_front.sv -----
// ----------------------------------------------------------------------------
// HTTP response header stripper: front
// Accepts response bytes, tracks capacity, the header delimiter and the
// status field, and pushes one entry per item that causes results.
// ----------------------------------------------------------------------------
module hrhs_front
  import hrhs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CAP_W-1:0]     cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  hrhs_in_t             in_item,
  input  logic                 q_full,
  output logic                 q_push,
  output hrhs_entry_t          q_entry
);

  logic [CAP_W-1:0]    capacity_r;
  logic [CAP_W-1:0]    byte_count_r, byte_count_nxt;
  logic [CAP_W-1:0]    body_count_r, body_count_nxt;
  logic                in_body_r, in_body_nxt;
  hrhs_dlm_t           dlm_r, dlm_nxt;
  hrhs_phase_t         phase_r, phase_nxt;
  logic [STATUS_W-1:0] acc_r, acc_nxt;

  logic                accept;
  logic                take_byte;
  logic                emit_body;
  logic [STATUS_W-1:0] digit_v;
  logic [7:0]          b;

  assign in_stall  = q_full;
  assign accept    = in_valid & ~q_full;
  assign b         = in_item.data_byte;
  assign take_byte = accept & in_item.byte_present & (byte_count_r < capacity_r);
  assign emit_body = take_byte & in_body_r;
  assign digit_v   = STATUS_W'({8'h00, b}) - STATUS_W'({8'h00, ASCII_ZERO});

  // Per-byte state update; the clear that follows a summary is done in the state register.
  always_comb begin
    byte_count_nxt = byte_count_r;
    body_count_nxt = body_count_r;
    in_body_nxt    = in_body_r;
    dlm_nxt        = dlm_r;
    phase_nxt      = phase_r;
    acc_nxt        = acc_r;

    if (take_byte) begin
      byte_count_nxt = byte_count_r + CAP_W'(1);

      // Status digits follow the first space.
      unique case (phase_r)
        PH_SEEK_SPACE: begin
          if (b == ASCII_SPACE) phase_nxt = PH_DIGIT1;
        end
        PH_DIGIT1: begin
          acc_nxt   = STATUS_W'(digit_v * WEIGHT_HUNDREDS);
          phase_nxt = PH_DIGIT2;
        end
        PH_DIGIT2: begin
          acc_nxt   = acc_r + STATUS_W'(digit_v * WEIGHT_TENS);
          phase_nxt = PH_DIGIT3;
        end
        PH_DIGIT3: begin
          acc_nxt   = acc_r + digit_v;
          phase_nxt = PH_NEED_MORE;
        end
        PH_NEED_MORE: begin
          phase_nxt = PH_VALID;
        end
        PH_VALID: begin
          phase_nxt = PH_VALID;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase

      if (in_body_r) begin
        body_count_nxt = body_count_r + CAP_W'(1);
      end else begin
        // Header delimiter matching.
        if (b == ASCII_CR) begin
          dlm_nxt = (dlm_r == DLM_CRLF) ? DLM_CRLFCR : DLM_CR;
        end else if (b == ASCII_LF) begin
          if (dlm_r == DLM_CR) begin
            dlm_nxt = DLM_CRLF;
          end else if (dlm_r == DLM_CRLFCR) begin
            dlm_nxt     = DLM_NONE;
            in_body_nxt = 1'b1;
          end else begin
            dlm_nxt = DLM_NONE;
          end
        end else begin
          dlm_nxt = DLM_NONE;
        end
      end
    end
  end

  // Queue entry for this item.
  always_comb begin
    q_entry             = '0;
    q_entry.has_byte    = emit_body;
    q_entry.has_sum     = in_item.end_of_response;
    q_entry.body_byte   = b;
    q_entry.error_code  = ERR_OK;
    if (byte_count_nxt == '0) begin
      q_entry.error_code = ERR_NO_BYTES;
    end else if (!in_body_nxt) begin
      q_entry.error_code = ERR_NO_DELIM;
    end else begin
      q_entry.body_length = body_count_nxt;
      q_entry.status_code = (phase_nxt == PH_VALID) ? acc_nxt : '0;
    end
  end

  assign q_push = accept & (emit_body | in_item.end_of_response);

  // Response state; a summary returns it to reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r   <= CAPACITY_RESET;
      byte_count_r <= '0;
      body_count_r <= '0;
      in_body_r    <= 1'b0;
      dlm_r        <= DLM_NONE;
      phase_r      <= PH_SEEK_SPACE;
      acc_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        capacity_r <= cfg_wr_data;
      end
      if (accept && in_item.end_of_response) begin
        byte_count_r <= '0;
        body_count_r <= '0;
        in_body_r    <= 1'b0;
        dlm_r        <= DLM_NONE;
        phase_r      <= PH_SEEK_SPACE;
        acc_r        <= '0;
      end else begin
        byte_count_r <= byte_count_nxt;
        body_count_r <= body_count_nxt;
        in_body_r    <= in_body_nxt;
        dlm_r        <= dlm_nxt;
        phase_r      <= phase_nxt;
        acc_r        <= acc_nxt;
      end
    end
  end

endmodule

// ----- design/hrhs_queue.sv -----
// ----------------------------------------------------------------------------
// HTTP response header stripper: entry queue
// Short register FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
module hrhs_queue
  import hrhs_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  hrhs_entry_t push_entry,
  input  logic        pop,
  output hrhs_entry_t pop_entry,
  output logic        full,
  output logic        empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  hrhs_entry_t      slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign do_push   = push & ~full;
  assign do_pop    = pop & ~empty;
  assign pop_entry = slot_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ----- design/hrhs_back.sv -----
// ----------------------------------------------------------------------------
// HTTP response header stripper: back
// Turns queue entries into result beats, a body byte ahead of the summary
// when one item causes both, through an output register.
// ----------------------------------------------------------------------------
module hrhs_back
  import hrhs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  hrhs_entry_t q_entry,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output hrhs_out_t   out_item
);

  logic        out_valid_r;
  hrhs_out_t   out_item_r, out_item_nxt;
  logic        pend_r;
  hrhs_entry_t pend_entry_r;
  logic        load;

  assign load  = ~out_valid_r | ~out_stall;
  assign q_pop = load & ~pend_r & ~q_empty;

  // Next result beat.
  always_comb begin
    out_item_nxt = '0;
    if (pend_r) begin
      out_item_nxt.kind        = KIND_SUMMARY;
      out_item_nxt.status_code = pend_entry_r.status_code;
      out_item_nxt.error_code  = pend_entry_r.error_code;
      out_item_nxt.body_length = pend_entry_r.body_length;
      out_item_nxt.last_result = 1'b1;
    end else if (q_entry.has_byte) begin
      out_item_nxt.kind        = KIND_BODY;
      out_item_nxt.body_byte   = q_entry.body_byte;
      out_item_nxt.last_result = ~q_entry.has_sum;
    end else begin
      out_item_nxt.kind        = KIND_SUMMARY;
      out_item_nxt.status_code = q_entry.status_code;
      out_item_nxt.error_code  = q_entry.error_code;
      out_item_nxt.body_length = q_entry.body_length;
      out_item_nxt.last_result = 1'b1;
    end
  end

  // Output register and the held summary.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (load) begin
      out_valid_r <= pend_r | ~q_empty;
      if (pend_r) begin
        pend_r <= 1'b0;
      end else if (!q_empty) begin
        pend_r <= q_entry.has_byte & q_entry.has_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= out_item_nxt;
    end
    if (q_pop) begin
      pend_entry_r <= q_entry;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- design/http_response_header_stripper.sv -----
// ----------------------------------------------------------------------------
// HTTP response header stripper
// Strips the header of an HTTP response, passes body bytes on and reports
// status, body length and an error code at the end of each response.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Beat
//  in_      input      in_valid/in_stall   one response byte and/or end mark
//  out_     output     out_valid/out_stall one body byte or one summary
//  cfg_     input      cfg_wr_en           capacity register write
//
// One input beat is taken per cycle while the entry queue has room.
// An item that carries both a body byte and the end mark needs two output
// beats, so a run of such items is limited by the output register to one
// result per cycle.
// Reset clears all response state and sets the capacity to 65536.
// Either side may stall on its own; the queue absorbs up to QUEUE_DEPTH items.
// ----------------------------------------------------------------------------
module http_response_header_stripper
  import hrhs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  hrhs_in_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output hrhs_out_t        out_item
);

  logic        q_full, q_empty, q_push, q_pop;
  hrhs_entry_t push_entry, pop_entry;

  // Front: accept and classify bytes.
  hrhs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (push_entry)
  );

  // Queue between front and back.
  hrhs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .full       (q_full),
    .empty      (q_empty)
  );

  // Back: emit result beats.
  hrhs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_entry   (pop_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ----- tb/sv/http_response_header_stripper_checker.sv -----
// ----------------------------------------------------------------------------
// HTTP response header stripper: result checker
// Watches the configuration port and both channels of the stripper. Each
// accepted input beat is run through a local model of the header parser.
// The body bytes and summaries it yields are queued, and every accepted
// output beat is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module http_response_header_stripper_checker
  import hrhs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  input  logic             in_stall,
  input  hrhs_in_t         in_item,
  input  logic             out_valid,
  input  logic             out_stall,
  input  hrhs_out_t        out_item,
  output int               fail_count,
  output int               pending_beats
);
  timeunit 1ns;
  timeprecision 1ps;

  // Local copy of the parser state and the capacity register.
  logic [CAP_W-1:0]    cap_limit;
  logic [CAP_W-1:0]    rx_count;
  logic [CAP_W-1:0]    body_count;
  logic                body_mode;
  hrhs_dlm_t           dlm_seen;
  hrhs_phase_t         status_phase;
  logic [STATUS_W-1:0] status_acc;

  // Body bytes and summaries still owed by the stripper, oldest first.
  hrhs_out_t owed_results[$];

  initial begin
    fail_count    = 0;
    pending_beats = 0;
  end

  // Start of a new response: everything but the capacity goes back to reset.
  task automatic clear_response();
    rx_count     = '0;
    body_count   = '0;
    body_mode    = 1'b0;
    dlm_seen     = DLM_NONE;
    status_phase = PH_SEEK_SPACE;
    status_acc   = '0;
  endtask

  // Advances the status field tracker by one accepted byte.
  task automatic track_status(input logic [7:0] b);
    logic [STATUS_W-1:0] digit;
    digit = {8'h00, b} - {8'h00, ASCII_ZERO};
    case (status_phase)
      PH_SEEK_SPACE: begin
        if (b == ASCII_SPACE) status_phase = PH_DIGIT1;
      end
      PH_DIGIT1: begin
        status_acc   = digit * WEIGHT_HUNDREDS;
        status_phase = PH_DIGIT2;
      end
      PH_DIGIT2: begin
        status_acc   = status_acc + digit * WEIGHT_TENS;
        status_phase = PH_DIGIT3;
      end
      PH_DIGIT3: begin
        status_acc   = status_acc + digit;
        status_phase = PH_NEED_MORE;
      end
      PH_NEED_MORE: begin
        status_phase = PH_VALID;
      end
      default: ;
    endcase
  endtask

  // Advances the CR LF CR LF matcher by one header byte.
  task automatic track_delimiter(input logic [7:0] b);
    if (b == ASCII_CR) begin
      if (dlm_seen == DLM_CRLF) dlm_seen = DLM_CRLFCR;
      else dlm_seen = DLM_CR;
    end else if (b == ASCII_LF) begin
      if (dlm_seen == DLM_CR) begin
        dlm_seen = DLM_CRLF;
      end else if (dlm_seen == DLM_CRLFCR) begin
        dlm_seen  = DLM_NONE;
        body_mode = 1'b1;
      end else begin
        dlm_seen = DLM_NONE;
      end
    end else begin
      dlm_seen = DLM_NONE;
    end
  endtask

  // Works out the results of one accepted input beat and queues them.
  task automatic parse_beat(input hrhs_in_t beat);
    hrhs_out_t body_res;
    hrhs_out_t sum_res;
    logic      has_body;
    logic      has_sum;
    body_res = '0;
    sum_res  = '0;
    has_body = 1'b0;
    has_sum  = 1'b0;

    // A byte past the capacity leaves no trace at all.
    if (beat.byte_present && rx_count < cap_limit) begin
      rx_count = rx_count + 1'b1;
      track_status(beat.data_byte);
      if (body_mode) begin
        body_count         = body_count + 1'b1;
        body_res.kind      = KIND_BODY;
        body_res.body_byte = beat.data_byte;
        has_body           = 1'b1;
      end else begin
        track_delimiter(beat.data_byte);
      end
    end

    if (beat.end_of_response) begin
      sum_res.kind = KIND_SUMMARY;
      if (rx_count == '0) begin
        sum_res.error_code = ERR_NO_BYTES;
      end else if (!body_mode) begin
        sum_res.error_code = ERR_NO_DELIM;
      end else begin
        sum_res.error_code  = ERR_OK;
        sum_res.status_code = (status_phase == PH_VALID) ? status_acc : '0;
        sum_res.body_length = body_count;
      end
      has_sum = 1'b1;
      clear_response();
    end

    if (has_body) begin
      body_res.last_result = !has_sum;
      owed_results.push_back(body_res);
    end
    if (has_sum) begin
      sum_res.last_result = 1'b1;
      owed_results.push_back(sum_res);
    end
  endtask

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  // Compares one accepted output beat with the oldest owed result.
  task automatic compare_beat(input hrhs_out_t got);
    hrhs_out_t want;
    if (owed_results.size() == 0) begin
      $error("result beat with none expected: kind %0d", got.kind);
      fail_count++;
    end else begin
      want = owed_results.pop_front();
      check_field("kind", want.kind, got.kind);
      check_field("body_byte", want.body_byte, got.body_byte);
      check_field("status_code", $signed(want.status_code), $signed(got.status_code));
      check_field("error_code", want.error_code, got.error_code);
      check_field("body_length", want.body_length, got.body_length);
      check_field("last_result", want.last_result, got.last_result);
    end
  endtask

  // Everything is sampled at the rising edge, before the edge takes effect.
  always @(posedge clk) begin
    if (!rst_n) begin
      cap_limit = CAPACITY_RESET;
      clear_response();
      owed_results.delete();
    end else begin
      if (cfg_wr_en) cap_limit = cfg_wr_data;
      if (out_valid && !out_stall) compare_beat(out_item);
      if (in_valid && !in_stall) parse_beat(in_item);
    end
    pending_beats = owed_results.size();
  end

endmodule

// ----- tb/sv/http_response_header_stripper_tb.sv -----
// ----------------------------------------------------------------------------
// HTTP response header stripper: testbench top
// Drives response byte streams into the stripper: a short directed set for
// the error summaries, status corner cases and byte extremes, then random
// responses under several capacity settings, with idle and stall bursts on
// both channels. The checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module http_response_header_stripper_tb
  import hrhs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to let in-flight beats that cause no result clear the pipeline.
  localparam int SETTLE_CYCLES = 10;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;
  logic             in_valid;
  logic             in_stall;
  hrhs_in_t         in_item;
  logic             out_valid;
  logic             out_stall;
  hrhs_out_t        out_item;

  int fail_count;
  int pending_beats;
  int sent_beats;
  int stall_left;
  bit idle_on;
  bit quiet_tail;

  http_response_header_stripper dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

  http_response_header_stripper_checker u_watch (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item      (out_item),
    .fail_count    (fail_count),
    .pending_beats (pending_beats)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net against a hung handshake.
  initial begin
    #5_000_000;
    $display("http_response_header_stripper: mismatch");
    $finish;
  end

  // Receiver: random stall bursts, none in the tail or while idle bursts are off.
  always @(posedge clk) begin
    if (!rst_n || quiet_tail || !idle_on) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(1, 15) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Sends one beat, held until accepted, after an optional idle burst.
  task automatic send_beat(input logic [7:0] b, input logic present, input logic eor);
    hrhs_in_t beat;
    beat.data_byte       = b;
    beat.byte_present    = present;
    beat.end_of_response = eor;
    if (idle_on && !quiet_tail && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_item  <= beat;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (present || eor) sent_beats++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b1, 1'b0);
  endtask

  task automatic send_delim();
    send_beat(ASCII_CR, 1'b1, 1'b0);
    send_beat(ASCII_LF, 1'b1, 1'b0);
    send_beat(ASCII_CR, 1'b1, 1'b0);
    send_beat(ASCII_LF, 1'b1, 1'b0);
  endtask

  // Header filler: printable text with stray CR and LF now and then.
  function automatic logic [7:0] header_char();
    case ($urandom_range(0, 7))
      0:       return ASCII_CR;
      1:       return ASCII_LF;
      default: return 8'($urandom_range(33, 126));
    endcase
  endfunction

  // Stops sending until every owed result is out and the pipeline is quiet.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_beats != 0);
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    drain_and_settle();
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // One random response: mostly well formed, some noise, some broken.
  task automatic send_response();
    int  pick;
    int  n;
    bit  end_on_byte;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      // Noise: any mix of bytes, end marks and empty beats.
      n = $urandom_range(1, 8);
      repeat (n) begin
        send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 3) == 0);
      end
    end else if (pick == 1) begin
      // Header with no delimiter sent on purpose; stray CR and LF may still form one.
      n = $urandom_range(0, 10);
      repeat (n) send_beat(header_char(), 1'b1, 1'b0);
      if ($urandom_range(0, 1) == 1) begin
        send_beat(ASCII_CR, 1'b1, 1'b0);
        send_beat(ASCII_LF, 1'b1, 1'b0);
        send_beat(ASCII_CR, 1'b1, 1'b0);
      end
      send_beat(8'($urandom_range(65, 90)), 1'($urandom_range(0, 1)), 1'b1);
    end else begin
      // Status line, header, delimiter, body, end.
      n = $urandom_range(0, 4);
      repeat (n) send_beat(8'($urandom_range(65, 90)), 1'b1, 1'b0);
      send_beat(ASCII_SPACE, 1'b1, 1'b0);
      repeat (3) begin
        if ($urandom_range(0, 4) == 0) send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        else send_beat(8'($urandom_range(48, 57)), 1'b1, 1'b0);
      end
      n = $urandom_range(0, 6);
      repeat (n) send_beat(header_char(), 1'b1, 1'b0);
      if ($urandom_range(0, 5) == 0) begin
        // A delimiter cut short by an ordinary byte.
        send_beat(ASCII_CR, 1'b1, 1'b0);
        send_beat(ASCII_LF, 1'b1, 1'b0);
        send_beat(ASCII_CR, 1'b1, 1'b0);
        send_beat(8'($urandom_range(65, 90)), 1'b1, 1'b0);
      end
      send_delim();
      n = $urandom_range(0, 12);
      if ($urandom_range(0, 19) == 0) n = $urandom_range(13, 80);
      end_on_byte = (n > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < n; i++) begin
        send_beat(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == n - 1));
      end
      if (!end_on_byte) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  task automatic run_phase(input int beats);
    int stop_at;
    stop_at = sent_beats + beats;
    idle_on = ($urandom_range(0, 3) != 0);
    while (sent_beats < stop_at) send_response();
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_item     = '0;
    idle_on     = 1'b1;
    quiet_tail  = 1'b0;
    sent_beats  = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // End mark with no bytes at all, then an empty beat.
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hFF, 1'b0, 1'b0);

    // Delimiter first, extreme status bytes, last byte together with the end.
    send_delim();
    send_beat(ASCII_SPACE, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat("Z", 1'b1, 1'b1);

    // Status but a delimiter that never completes.
    send_text(" 200");
    send_beat(ASCII_CR, 1'b1, 1'b0);
    send_beat(ASCII_LF, 1'b1, 1'b0);
    send_beat(ASCII_CR, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);

    // Status digits cut off by the end: no byte follows, so status is zero.
    send_delim();
    send_text(" 1");
    send_beat("2", 1'b1, 1'b1);

    // Random part across capacity settings, reset value first.
    run_phase(300);
    write_capacity(20'd1);
    run_phase(60);
    write_capacity(20'd0);
    run_phase(30);
    write_capacity(20'hFFFFF);
    run_phase(250);
    write_capacity(20'($urandom_range(8, 40)));
    run_phase(200);
    write_capacity(20'($urandom_range(1, 20'hFFFFF)));
    run_phase(200);
    write_capacity(CAPACITY_RESET);
    quiet_tail = 1'b1;
    run_phase(150);

    drain_and_settle();
    if (fail_count == 0) begin
      $display("http_response_header_stripper: match");
    end else begin
      $display("http_response_header_stripper: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/hrhs_pkg.sv
design/hrhs_front.sv
design/hrhs_queue.sv
design/hrhs_back.sv
design/http_response_header_stripper.sv
tb/sv/http_response_header_stripper_checker.sv
tb/sv/http_response_header_stripper_tb.sv
